// ===== rtl/crc8rbf_pkg.sv =====
// ----------------------------------------------------------------------------
// crc8rbf_pkg
// Shared types, register indexes, status codes and the CRC-8 byte step used by
// the register block framing logic.
// ----------------------------------------------------------------------------
package crc8rbf_pkg;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_ADDR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_CRC_POLY = 1'b1;

    // Reset values of the configuration registers
    localparam logic [6:0] RST_DEV_ADDR = 7'd8;
    localparam logic [7:0] RST_CRC_POLY = 8'h07;

    localparam logic [7:0] MSB_MASK = 8'h80;

    // Result status codes
    localparam logic [1:0] ST_WRITE    = 2'd0;
    localparam logic [1:0] ST_VERIFIED = 2'd1;
    localparam logic [1:0] ST_MISMATCH = 2'd2;

    // Results produced by one input item: up to three bytes, one status
    typedef struct packed {
        logic [1:0] count;
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [7:0] byte2;
        logic [1:0] status;
    } load_t;

    // One byte through an MSB-first CRC-8 that starts from zero. Feeding byte b
    // into a running crc c equals crc8_byte(poly, c ^ b).
    function automatic logic [7:0] crc8_byte(input logic [7:0] poly,
                                             input logic [7:0] data);
        logic [7:0] crc;
        logic       fb;
        crc = data;
        for (int i = 0; i < 8; i++)
        begin
            fb  = (crc & MSB_MASK) != 8'h00;
            crc = {crc[6:0], 1'b0};
            if (fb)
            begin
                crc = crc ^ poly;
            end
        end
        return crc;
    endfunction

endpackage

// ===== rtl/crc8rbf_result_q.sv =====
// ----------------------------------------------------------------------------
// crc8rbf_result_q
// Result register: holds the up to three result bytes of one item and hands
// them out one transaction per cycle while out_stall is low, flagging the final one.
// ----------------------------------------------------------------------------
module crc8rbf_result_q (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  crc8rbf_pkg::load_t  load_data,
    output logic                free,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          byte_out,
    output logic [1:0]          status,
    output logic                last
);

    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [7:0] byte0_reg;
    logic [7:0] byte1_reg;
    logic [7:0] byte2_reg;
    logic [1:0] status_reg;
    logic       take;

    assign take      = out_valid && !out_stall;
    assign out_valid = count_reg != 2'd0;
    assign last      = count_reg == 2'd1;
    assign byte_out  = byte0_reg;
    assign status    = status_reg;

    // Free once empty or when the final result leaves this cycle
    assign free = (count_reg == 2'd0) || (last && take);

    // Advance the count on each output transaction, reload from the core
    always_comb
    begin
        count_next = count_reg;
        if (take)
        begin
            count_next = count_reg - 2'd1;
        end
        if (load)
        begin
            count_next = load_data.count;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    // Shift payload forward on each transaction, or load a new set
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte0_reg  <= load_data.byte0;
            byte1_reg  <= load_data.byte1;
            byte2_reg  <= load_data.byte2;
            status_reg <= load_data.status;
        end
        else if (take)
        begin
            byte0_reg <= byte1_reg;
            byte1_reg <= byte2_reg;
        end
    end

endmodule

// ===== rtl/crc8_register_block_framing.sv =====
// ----------------------------------------------------------------------------
// crc8_register_block_framing
// Frames outgoing register write blocks with a CRC-8 and checks incoming read
// data/CRC pairs, dropping the rest of a read block after a mismatch.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in      | input     | in_valid/in_stall  | req_type, byte_in, first, reg_addr
//  out     | output    | out_valid/out_stall| byte_out, status, last
//  cfg     | input     | cfg_wr_en          | cfg_index, cfg_wdata
//
// An item is taken into an input register, processed by a single CRC byte
// step and loaded into the result register once that is free; until then it
// waits in the input register. A new item can enter every cycle while the
// result register frees up; while a write item's results drain, one item waits
// in the input register and the input stalls. A write item gives two or three
// output bytes, a read item at most one, so throughput is set by the output
// transactions. Address CRCs are refreshed on the config write itself.
// Reset is asynchronous and clears all control state.
// ----------------------------------------------------------------------------
module crc8_register_block_framing (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_wr_en,
    input  logic [crc8rbf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [7:0]                           cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic [7:0]                           byte_in,
    input  logic                                 first,
    input  logic [7:0]                           reg_addr,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [7:0]                           byte_out,
    output logic [1:0]                           status,
    output logic                                 last
);

    // Configuration and derived address CRCs
    logic [6:0] dev_addr_reg;
    logic [7:0] crc_poly_reg;
    logic [7:0] wr_addr_crc_reg;
    logic [7:0] rd_addr_crc_reg;
    logic [6:0] dev_addr_next;
    logic [7:0] crc_poly_next;

    // Input register
    logic       in_full_reg;
    logic       req_type_reg;
    logic [7:0] byte_in_reg;
    logic       first_reg;
    logic [7:0] reg_addr_reg;
    logic [7:0] pre_crc_reg;

    // Read pair state
    logic       expect_crc_reg;
    logic       expect_crc_next;
    logic       discarding_reg;
    logic       discarding_next;
    logic [7:0] held_byte_reg;
    logic [7:0] held_byte_next;
    logic [7:0] held_crc_reg;
    logic [7:0] held_crc_next;

    logic                 take_in;
    logic                 move;
    logic                 q_free;
    logic [7:0]           crc_arg;
    logic [7:0]           crc_val;
    crc8rbf_pkg::load_t   load_data;

    assign take_in  = in_valid && !in_stall;
    assign move     = in_full_reg && q_free;
    assign in_stall = in_full_reg && !q_free;

    // Pick the register value being written, else hold
    always_comb
    begin
        dev_addr_next = dev_addr_reg;
        crc_poly_next = crc_poly_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_index)
                crc8rbf_pkg::REG_DEV_ADDR: dev_addr_next = cfg_wdata[6:0];
                crc8rbf_pkg::REG_CRC_POLY: crc_poly_next = cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_addr_reg    <= crc8rbf_pkg::RST_DEV_ADDR;
            crc_poly_reg    <= crc8rbf_pkg::RST_CRC_POLY;
            wr_addr_crc_reg <= crc8rbf_pkg::crc8_byte(crc8rbf_pkg::RST_CRC_POLY,
                                                      {crc8rbf_pkg::RST_DEV_ADDR, 1'b0});
            rd_addr_crc_reg <= crc8rbf_pkg::crc8_byte(crc8rbf_pkg::RST_CRC_POLY,
                                                      {crc8rbf_pkg::RST_DEV_ADDR, 1'b1});
        end
        else
        begin
            dev_addr_reg    <= dev_addr_next;
            crc_poly_reg    <= crc_poly_next;
            wr_addr_crc_reg <= crc8rbf_pkg::crc8_byte(crc_poly_next, {dev_addr_next, 1'b0});
            rd_addr_crc_reg <= crc8rbf_pkg::crc8_byte(crc_poly_next, {dev_addr_next, 1'b1});
        end
    end

    // Hold the input transaction; fold the register byte into the address CRC
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg <= 1'b0;
        end
        else if (take_in)
        begin
            in_full_reg <= 1'b1;
        end
        else if (move)
        begin
            in_full_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_in)
        begin
            req_type_reg <= req_type;
            byte_in_reg  <= byte_in;
            first_reg    <= first;
            reg_addr_reg <= reg_addr;
            pre_crc_reg  <= crc8rbf_pkg::crc8_byte(crc_poly_reg, wr_addr_crc_reg ^ reg_addr);
        end
    end

    // One CRC byte step serves both item kinds
    always_comb
    begin
        if (!req_type_reg)
        begin
            crc_arg = first_reg ? (pre_crc_reg ^ byte_in_reg) : byte_in_reg;
        end
        else
        begin
            crc_arg = first_reg ? (rd_addr_crc_reg ^ byte_in_reg) : byte_in_reg;
        end
    end

    assign crc_val = crc8rbf_pkg::crc8_byte(crc_poly_reg, crc_arg);

    // Build the results and the next read state
    always_comb
    begin
        load_data        = '0;
        load_data.status = crc8rbf_pkg::ST_WRITE;
        expect_crc_next  = expect_crc_reg;
        discarding_next  = discarding_reg;
        held_byte_next   = held_byte_reg;
        held_crc_next    = held_crc_reg;
        if (!req_type_reg)
        begin
            if (first_reg)
            begin
                load_data.count = 2'd3;
                load_data.byte0 = reg_addr_reg;
                load_data.byte1 = byte_in_reg;
                load_data.byte2 = crc_val;
            end
            else
            begin
                load_data.count = 2'd2;
                load_data.byte0 = byte_in_reg;
                load_data.byte1 = crc_val;
            end
        end
        else
        begin
            priority if (first_reg)
            begin
                discarding_next = 1'b0;
                expect_crc_next = 1'b1;
                held_byte_next  = byte_in_reg;
                held_crc_next   = crc_val;
            end
            else if (discarding_reg)
            begin
                expect_crc_next = expect_crc_reg;
            end
            else if (!expect_crc_reg)
            begin
                expect_crc_next = 1'b1;
                held_byte_next  = byte_in_reg;
                held_crc_next   = crc_val;
            end
            else
            begin
                expect_crc_next = 1'b0;
                load_data.count = 2'd1;
                load_data.byte0 = held_byte_reg;
                if (held_crc_reg == byte_in_reg)
                begin
                    load_data.status = crc8rbf_pkg::ST_VERIFIED;
                end
                else
                begin
                    load_data.status = crc8rbf_pkg::ST_MISMATCH;
                    discarding_next  = 1'b1;
                end
            end
        end
    end

    // Advance read state when an item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_crc_reg <= 1'b0;
            discarding_reg <= 1'b0;
            held_byte_reg  <= 8'h00;
            held_crc_reg   <= 8'h00;
        end
        else if (move)
        begin
            expect_crc_reg <= expect_crc_next;
            discarding_reg <= discarding_next;
            held_byte_reg  <= held_byte_next;
            held_crc_reg   <= held_crc_next;
        end
    end

    crc8rbf_result_q u_result_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (move),
        .load_data (load_data),
        .free      (q_free),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .byte_out  (byte_out),
        .status    (status),
        .last      (last)
    );

endmodule
